/* rtl/vsl_pkg.sv */
package vsl_pkg;

    // sample width, Q16.16 by default
    localparam int SW = 32;
    localparam int TS_W = 32;

    // step length: up to (2^32 - 1) ms times 1000 us
    localparam int PW = 42;
    localparam int CHUNK_W = 16;
    localparam int PCH = (PW + CHUNK_W - 1) / CHUNK_W;
    localparam int PPW = PCH * CHUNK_W;
    localparam int KW = (PCH > 1) ? $clog2(PCH) : 1;

    // denominator p + T and divider remainder
    localparam int DEN_W = PW + 1;
    localparam int RW = DEN_W + 1;

    // frequency quotient 1000*65536/d stays below 2^26
    localparam int FREQ_QW = 26;
    localparam int QW = (SW + 1 > FREQ_QW) ? SW + 1 : FREQ_QW;
    localparam int DW = SW + PW;
    localparam int CW = $clog2(QW + 1);

    // multiplier operand a holds either the magnitude or the ms step
    localparam int MAW = (SW > TS_W) ? SW : TS_W;

    // configuration port
    localparam int CFG_W = (SW > 32) ? SW : 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 1'b1;

    localparam logic [31:0] TC_RESET = 32'd1000000;
    localparam logic [CHUNK_W-1:0] MS_TO_US = 16'd1000;
    localparam logic [TS_W-1:0] FREQ_NUM = 32'd65536000;
    localparam logic [QW-1:0] SMAX_Q = QW'((64'd1 << (SW - 1)) - 64'd1);

    typedef enum logic [1:0] {
        OP_TIMED  = 2'd0,
        OP_FREQ   = 2'd1,
        OP_PERIOD = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_FDIV,
        S_FWAIT,
        S_PREP,
        S_MUL,
        S_DIV,
        S_DWAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        opcode_t               opcode;
        logic signed [SW-1:0]  sample;
        logic [TS_W-1:0]       timestamp_ms;
        logic [31:0]           explicit_period_us;
    } vsl_in_t;

    typedef struct packed {
        logic signed [SW-1:0]  filtered;
        logic [TS_W-1:0]       period_ms;
    } vsl_out_t;

    typedef struct packed {
        logic           start;
        logic [DW-1:0]  dividend;
        logic [RW-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [QW-1:0]  quotient;
    } div_rsp_t;

endpackage

/* rtl/vsl_div.sv */
module vsl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  vsl_pkg::div_req_t  req,
    output vsl_pkg::div_rsp_t  rsp
);
    import vsl_pkg::*;

    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [RW-1:0] divisor_reg, divisor_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW-1:0] trial;
    logic          fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg[RW-2:0], low_reg[QW-1]};
        fits = (trial >= divisor_reg);
    end

    always_comb
    begin
        rem_next = rem_reg;
        low_next = low_reg;
        divisor_next = divisor_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // upper dividend bits are known to lie below the divisor
            rem_next = RW'(req.dividend >> QW);
            low_next = req.dividend[QW-1:0];
            divisor_next = req.divisor;
            cnt_next = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - divisor_reg) : trial;
            low_next = {low_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = low_reg;

endmodule

/* rtl/variable_step_lowpass_filter.sv */
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_stall   | in_data: opcode, sample, timestamp, period
// out      | output    | out_valid / out_stall | out_data: filtered, period_ms
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request at a time; the run time is set by the radix-2 divider (one quotient bit
// per cycle, 33 steps), which opcode 1 runs twice: once for the event frequency,
// once for the filter.
// zero-period and unused-opcode requests finish without using the divider.
// rst_n is asynchronous; after reset the time constant is 1 s and the state is zero.
// a finished result waits in the output register while the next request is taken.
module variable_step_lowpass_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  vsl_pkg::vsl_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output vsl_pkg::vsl_out_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vsl_pkg::CFG_W-1:0]         cfg_data
);
    import vsl_pkg::*;

    state_t               state_reg, state_next;
    opcode_t              op_reg, op_next;
    logic                 zero_reg, zero_next;
    logic signed [SW-1:0] x_reg, x_next;
    logic signed [SW-1:0] y_reg, y_next;
    logic [TS_W-1:0]      ts_reg, ts_next;
    logic [TS_W-1:0]      last_ts_reg, last_ts_next;
    logic [TS_W-1:0]      d_reg, d_next;
    logic [31:0]          tc_reg, tc_next;
    logic [PPW-1:0]       p_reg, p_next;
    logic [RW-1:0]        den_reg, den_next;
    logic [SW-1:0]        mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [DW-1:0]        acc_reg, acc_next;
    logic [KW-1:0]        k_reg, k_next;
    vsl_out_t             out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 accept;
    logic                 cfg_we;
    logic                 done_fire;
    logic [TS_W-1:0]      ts_diff;
    logic [SW:0]          delta;
    logic [SW:0]          delta_abs;
    logic [RW-1:0]        den_sum;
    logic [CHUNK_W-1:0]   p_chunk;
    logic [MAW-1:0]       mul_a;
    logic [CHUNK_W-1:0]   mul_b;
    logic [MAW+CHUNK_W-1:0] mul_prod;
    logic [SW-1:0]        y_step;
    logic [SW-1:0]        freq_x;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    vsl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // handshakes
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept = in_valid && !in_stall;
    assign cfg_we = cfg_valid && cfg_ready;
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // shared arithmetic
    always_comb
    begin
        ts_diff = in_data.timestamp_ms - last_ts_reg;
        delta = {x_reg[SW-1], x_reg} - {y_reg[SW-1], y_reg};
        delta_abs = delta[SW] ? (-delta) : delta;
        den_sum = RW'(p_reg[PW-1:0]) + RW'(tc_reg);
        p_chunk = p_reg[k_reg * CHUNK_W +: CHUNK_W];
        // ms-to-us scaling and the partial products share one multiplier
        mul_a = (state_reg == S_PMUL) ? MAW'(d_reg) : MAW'(mag_reg);
        mul_b = (state_reg == S_PMUL) ? MS_TO_US : p_chunk;
        mul_prod = mul_a * mul_b;
        y_step = neg_reg ? (y_reg - div_rsp.quotient[SW-1:0])
                         : (y_reg + div_rsp.quotient[SW-1:0]);
        freq_x = (div_rsp.quotient > SMAX_Q) ? SMAX_Q[SW-1:0]
                                             : div_rsp.quotient[SW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.opcode)
                        OP_TIMED, OP_FREQ:
                            state_next = S_PMUL;
                        OP_PERIOD:
                            state_next = (in_data.explicit_period_us == '0) ? S_DONE : S_PREP;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_PMUL:
                state_next = (op_reg == OP_FREQ) ? S_FDIV : S_PREP;
            S_FDIV:
                state_next = S_FWAIT;
            S_FWAIT:
                if (div_rsp.done)
                    state_next = S_PREP;
            S_PREP:
                state_next = S_MUL;
            S_MUL:
                if (k_reg == KW'(PCH - 1))
                    state_next = S_DIV;
            S_DIV:
                state_next = S_DWAIT;
            S_DWAIT:
                if (div_rsp.done)
                    state_next = S_DONE;
            S_DONE:
                if (done_fire)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and unit control per state
    always_comb
    begin
        op_next = op_reg;
        zero_next = zero_reg;
        x_next = x_reg;
        y_next = y_reg;
        ts_next = ts_reg;
        last_ts_next = last_ts_reg;
        d_next = d_reg;
        tc_next = tc_reg;
        p_next = p_reg;
        den_next = den_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        k_next = k_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_req.start = 1'b0;
        div_req.dividend = acc_reg;
        div_req.divisor = den_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIME_CONSTANT:
                    if (cfg_data[31:0] != '0)
                        tc_next = cfg_data[31:0];
                CFG_START_VALUE:
                    y_next = cfg_data[SW-1:0];
                default:
                    tc_next = tc_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = in_data.opcode;
                    x_next = in_data.sample;
                    ts_next = in_data.timestamp_ms;
                    d_next = (ts_diff == '0) ? TS_W'(1) : ts_diff;
                    p_next = PPW'(in_data.explicit_period_us);
                    zero_next = (in_data.opcode == OP_PERIOD)
                                && (in_data.explicit_period_us == '0);
                end
            end
            S_PMUL:
            begin
                // step in microseconds
                p_next = PPW'(mul_prod);
            end
            S_FDIV:
            begin
                // rounded event frequency
                div_req.start = 1'b1;
                div_req.dividend = DW'(FREQ_NUM + {1'b0, d_reg[TS_W-1:1]});
                div_req.divisor = RW'(d_reg);
            end
            S_FWAIT:
                if (div_rsp.done)
                    x_next = freq_x;
            S_PREP:
            begin
                // rounding term seeds the product accumulator
                den_next = den_sum;
                neg_next = delta[SW];
                mag_next = delta_abs[SW-1:0];
                acc_next = DW'(den_sum >> 1);
                k_next = '0;
            end
            S_MUL:
            begin
                acc_next = acc_reg + (DW'(mul_prod) << (k_reg * CHUNK_W));
                k_next = k_reg + KW'(1);
            end
            S_DIV:
                div_req.start = 1'b1;
            S_DONE:
            begin
                if (done_fire)
                begin
                    out_valid_next = 1'b1;
                    out_next.filtered = zero_reg ? '0 : y_step;
                    out_next.period_ms = (op_reg inside {OP_TIMED, OP_FREQ}) ? d_reg : '0;
                    if (!zero_reg)
                        y_next = y_step;
                    if (op_reg inside {OP_TIMED, OP_FREQ})
                        last_ts_next = ts_reg;
                end
            end
            default:
                out_next = out_reg;
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            tc_reg <= TC_RESET;
            y_reg <= '0;
            last_ts_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            tc_reg <= tc_next;
            y_reg <= y_next;
            last_ts_reg <= last_ts_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        zero_reg <= zero_next;
        x_reg <= x_next;
        ts_reg <= ts_next;
        d_reg <= d_next;
        p_reg <= p_next;
        den_reg <= den_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        k_reg <= k_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_FWAIT || state_reg == S_DWAIT))
        else $error("divider finished outside a wait state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result appeared without a finished request");

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !zero_reg) |-> (div_rsp.quotient <= QW'(mag_reg)))
        else $error("filter step larger than input difference");
`endif

endmodule
